// ===== hdl/box_to_world_aabb_defines.svh =====
// Assertion macros shared by the box_to_world_aabb RTL.
`ifndef BOX_TO_WORLD_AABB_DEFINES_SVH
`define BOX_TO_WORLD_AABB_DEFINES_SVH

// Same-cycle implication, sampled on i_clk and disabled while i_rst_n is low.
`define BTA_ASSERT_SAME(lbl, ant, con, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |-> (con)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk and disabled while i_rst_n is low.
`define BTA_ASSERT_NEXT(lbl, ant, con, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |=> (con)) \
        else $error(msg);

`endif

// ===== hdl/bta_pkg.sv =====
`timescale 1ns / 1ps
package bta_pkg;

    localparam int WORD_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF = 16;

    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_BOX_MIN_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_MIN_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_MIN_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_MAX_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_MAX_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_MAX_Z = 3'd5;

    typedef struct packed {
        logic en_prod;
        logic en_sel;
        logic en_sum;
        logic en_out;
        logic out_valid;
    } t_pipe_ctl;

endpackage

// ===== hdl/bta_axis.sv =====
`timescale 1ns / 1ps
`include "box_to_world_aabb_defines.svh"
module bta_axis #(
    parameter int WORD_BITS = bta_pkg::WORD_BITS_DEF,
    parameter int FRAC_BITS = bta_pkg::FRAC_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  bta_pkg::t_pipe_ctl          i_ctl,
    input  logic signed [WORD_BITS-1:0] i_c0,
    input  logic signed [WORD_BITS-1:0] i_c1,
    input  logic signed [WORD_BITS-1:0] i_c2,
    input  logic signed [WORD_BITS-1:0] i_c3,
    input  logic signed [WORD_BITS-1:0] i_box_min_x,
    input  logic signed [WORD_BITS-1:0] i_box_min_y,
    input  logic signed [WORD_BITS-1:0] i_box_min_z,
    input  logic signed [WORD_BITS-1:0] i_box_max_x,
    input  logic signed [WORD_BITS-1:0] i_box_max_y,
    input  logic signed [WORD_BITS-1:0] i_box_max_z,
    output logic signed [WORD_BITS-1:0] o_min,
    output logic signed [WORD_BITS-1:0] o_max,
    output logic signed [WORD_BITS-1:0] o_center,
    output logic        [WORD_BITS-2:0] o_half
);

    localparam int PW = 2 * WORD_BITS - FRAC_BITS;
    localparam int SW = PW + 2;
    localparam logic signed [WORD_BITS-1:0] WORD_MAX = {1'b0, {(WORD_BITS - 1){1'b1}}};
    localparam logic signed [WORD_BITS-1:0] WORD_MIN = {1'b1, {(WORD_BITS - 1){1'b0}}};

    logic signed [WORD_BITS-1:0]   w_coef [3];
    logic signed [WORD_BITS-1:0]   w_bmin [3];
    logic signed [WORD_BITS-1:0]   w_bmax [3];
    logic signed [2*WORD_BITS-1:0] w_full_min [3];
    logic signed [2*WORD_BITS-1:0] w_full_max [3];

    logic signed [PW-1:0]        n_pmin [3];
    logic signed [PW-1:0]        n_pmax [3];
    logic signed [PW-1:0]        r_pmin [3];
    logic signed [PW-1:0]        r_pmax [3];
    logic signed [WORD_BITS-1:0] r_t2;

    logic signed [PW-1:0]        n_lo3 [3];
    logic signed [PW-1:0]        n_hi3 [3];
    logic signed [PW-1:0]        r_lo3 [3];
    logic signed [PW-1:0]        r_hi3 [3];
    logic signed [WORD_BITS-1:0] r_t3;

    logic signed [SW-1:0]        w_sum_lo;
    logic signed [SW-1:0]        w_sum_hi;
    logic signed [WORD_BITS-1:0] n_lo4;
    logic signed [WORD_BITS-1:0] n_hi4;
    logic signed [WORD_BITS-1:0] r_lo4;
    logic signed [WORD_BITS-1:0] r_hi4;

    logic signed [WORD_BITS:0]   w_mid_sum;
    logic signed [WORD_BITS:0]   w_span;
    logic signed [WORD_BITS-1:0] r_min;
    logic signed [WORD_BITS-1:0] r_max;
    logic signed [WORD_BITS-1:0] r_center;
    logic        [WORD_BITS-2:0] r_half;

    assign w_coef = '{i_c0, i_c1, i_c2};
    assign w_bmin = '{i_box_min_x, i_box_min_y, i_box_min_z};
    assign w_bmax = '{i_box_max_x, i_box_max_y, i_box_max_z};

    // Each product is floored by dropping its fraction bits.
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            w_full_min[j] = w_coef[j] * w_bmin[j];
            w_full_max[j] = w_coef[j] * w_bmax[j];
            n_pmin[j] = w_full_min[j][2*WORD_BITS-1:FRAC_BITS];
            n_pmax[j] = w_full_max[j][2*WORD_BITS-1:FRAC_BITS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en_prod) begin
            r_pmin <= n_pmin;
            r_pmax <= n_pmax;
            r_t2   <= i_c3;
        end
    end

    // The row sum is separable per column, so the corner extremes come from
    // the per-column extremes.
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            if (r_pmin[j] < r_pmax[j]) begin
                n_lo3[j] = r_pmin[j];
                n_hi3[j] = r_pmax[j];
            end else begin
                n_lo3[j] = r_pmax[j];
                n_hi3[j] = r_pmin[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en_sel) begin
            r_lo3 <= n_lo3;
            r_hi3 <= n_hi3;
            r_t3  <= r_t2;
        end
    end

    assign w_sum_lo = SW'(r_lo3[0]) + SW'(r_lo3[1]) + SW'(r_lo3[2]) + SW'(r_t3);
    assign w_sum_hi = SW'(r_hi3[0]) + SW'(r_hi3[1]) + SW'(r_hi3[2]) + SW'(r_t3);

    always_comb begin
        if ((&w_sum_lo[SW-1:WORD_BITS-1]) || !(|w_sum_lo[SW-1:WORD_BITS-1])) begin
            n_lo4 = w_sum_lo[WORD_BITS-1:0];
        end else begin
            n_lo4 = w_sum_lo[SW-1] ? WORD_MIN : WORD_MAX;
        end
        if ((&w_sum_hi[SW-1:WORD_BITS-1]) || !(|w_sum_hi[SW-1:WORD_BITS-1])) begin
            n_hi4 = w_sum_hi[WORD_BITS-1:0];
        end else begin
            n_hi4 = w_sum_hi[SW-1] ? WORD_MIN : WORD_MAX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en_sum) begin
            r_lo4 <= n_lo4;
            r_hi4 <= n_hi4;
        end
    end

    assign w_mid_sum = {r_lo4[WORD_BITS-1], r_lo4} + {r_hi4[WORD_BITS-1], r_hi4};
    assign w_span    = {r_hi4[WORD_BITS-1], r_hi4} - {r_lo4[WORD_BITS-1], r_lo4};

    always_ff @(posedge i_clk) begin
        if (i_ctl.en_out) begin
            r_min    <= r_lo4;
            r_max    <= r_hi4;
            r_center <= w_mid_sum[WORD_BITS:1];
            r_half   <= w_span[WORD_BITS-1:1];
        end
    end

    assign o_min    = r_min;
    assign o_max    = r_max;
    assign o_center = r_center;
    assign o_half   = r_half;

    `BTA_ASSERT_SAME(ax_min_le_max, i_ctl.out_valid, r_min <= r_max, "axis minimum above maximum")
    `BTA_ASSERT_SAME(ax_center_inside, i_ctl.out_valid,
                     (r_center >= r_min) && (r_center <= r_max), "axis center outside box")
    `BTA_ASSERT_NEXT(ax_hold_on_stall, i_ctl.out_valid && !i_ctl.en_out,
                     $stable(r_min) && $stable(r_max), "axis result changed while stalled")

endmodule

// ===== hdl/box_to_world_aabb.sv =====
`timescale 1ns / 1ps
`include "box_to_world_aabb_defines.svh"
// Transforms the configured local box by the upper three rows of an affine
// matrix and returns the world-space bounding box with its center and half
// extent. The block takes one item per cycle while the output is not stalled;
// the pipeline is input register, products, per-column min/max, saturated row
// sums, and the output register. The rate is set by the 18 parallel multipliers,
// two per coefficient of the first three matrix columns, one for the box minimum
// and one for the maximum. Results leave in acceptance order, and a stall on the
// output holds the whole pipeline once its empty slots have filled.
module box_to_world_aabb #(
    parameter int WORD_BITS = bta_pkg::WORD_BITS_DEF,
    parameter int FRAC_BITS = bta_pkg::FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [bta_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [WORD_BITS-1:0]          i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic signed [WORD_BITS-1:0]   i_m_r0c0,
    input  logic signed [WORD_BITS-1:0]   i_m_r0c1,
    input  logic signed [WORD_BITS-1:0]   i_m_r0c2,
    input  logic signed [WORD_BITS-1:0]   i_m_r0c3,
    input  logic signed [WORD_BITS-1:0]   i_m_r1c0,
    input  logic signed [WORD_BITS-1:0]   i_m_r1c1,
    input  logic signed [WORD_BITS-1:0]   i_m_r1c2,
    input  logic signed [WORD_BITS-1:0]   i_m_r1c3,
    input  logic signed [WORD_BITS-1:0]   i_m_r2c0,
    input  logic signed [WORD_BITS-1:0]   i_m_r2c1,
    input  logic signed [WORD_BITS-1:0]   i_m_r2c2,
    input  logic signed [WORD_BITS-1:0]   i_m_r2c3,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic signed [WORD_BITS-1:0]   o_aabb_min_x,
    output logic signed [WORD_BITS-1:0]   o_aabb_min_y,
    output logic signed [WORD_BITS-1:0]   o_aabb_min_z,
    output logic signed [WORD_BITS-1:0]   o_aabb_max_x,
    output logic signed [WORD_BITS-1:0]   o_aabb_max_y,
    output logic signed [WORD_BITS-1:0]   o_aabb_max_z,
    output logic signed [WORD_BITS-1:0]   o_center_x,
    output logic signed [WORD_BITS-1:0]   o_center_y,
    output logic signed [WORD_BITS-1:0]   o_center_z,
    output logic        [WORD_BITS-2:0]   o_half_extent_x,
    output logic        [WORD_BITS-2:0]   o_half_extent_y,
    output logic        [WORD_BITS-2:0]   o_half_extent_z
);

    logic signed [WORD_BITS-1:0] r_box_min [3];
    logic signed [WORD_BITS-1:0] r_box_max [3];
    logic signed [WORD_BITS-1:0] r_m [3][4];

    logic [4:0] r_vld;
    logic [4:0] n_vld;
    logic [4:0] w_rdy;

    bta_pkg::t_pipe_ctl w_ctl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box_min <= '{default: '0};
            r_box_max <= '{default: '0};
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                bta_pkg::CFG_BOX_MIN_X: r_box_min[0] <= i_cfg_data;
                bta_pkg::CFG_BOX_MIN_Y: r_box_min[1] <= i_cfg_data;
                bta_pkg::CFG_BOX_MIN_Z: r_box_min[2] <= i_cfg_data;
                bta_pkg::CFG_BOX_MAX_X: r_box_max[0] <= i_cfg_data;
                bta_pkg::CFG_BOX_MAX_Y: r_box_max[1] <= i_cfg_data;
                bta_pkg::CFG_BOX_MAX_Z: r_box_max[2] <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // A stage takes new data when it is empty or its successor takes its item.
    always_comb begin
        w_rdy[4] = !r_vld[4] || i_out_ready;
        for (int k = 3; k >= 0; k--) begin
            w_rdy[k] = !r_vld[k] || w_rdy[k+1];
        end
        n_vld[0] = w_rdy[0] ? i_in_valid : r_vld[0];
        for (int k = 1; k < 5; k++) begin
            n_vld[k] = w_rdy[k] ? r_vld[k-1] : r_vld[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r_m <= '{'{i_m_r0c0, i_m_r0c1, i_m_r0c2, i_m_r0c3},
                     '{i_m_r1c0, i_m_r1c1, i_m_r1c2, i_m_r1c3},
                     '{i_m_r2c0, i_m_r2c1, i_m_r2c2, i_m_r2c3}};
        end
    end

    assign w_ctl.en_prod   = w_rdy[1];
    assign w_ctl.en_sel    = w_rdy[2];
    assign w_ctl.en_sum    = w_rdy[3];
    assign w_ctl.en_out    = w_rdy[4];
    assign w_ctl.out_valid = r_vld[4];

    logic signed [WORD_BITS-1:0] w_min [3];
    logic signed [WORD_BITS-1:0] w_max [3];
    logic signed [WORD_BITS-1:0] w_center [3];
    logic        [WORD_BITS-2:0] w_half [3];

    for (genvar g = 0; g < 3; g++) begin : g_axis
        bta_axis #(
            .WORD_BITS(WORD_BITS),
            .FRAC_BITS(FRAC_BITS)
        ) u_axis (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (w_ctl),
            .i_c0       (r_m[g][0]),
            .i_c1       (r_m[g][1]),
            .i_c2       (r_m[g][2]),
            .i_c3       (r_m[g][3]),
            .i_box_min_x(r_box_min[0]),
            .i_box_min_y(r_box_min[1]),
            .i_box_min_z(r_box_min[2]),
            .i_box_max_x(r_box_max[0]),
            .i_box_max_y(r_box_max[1]),
            .i_box_max_z(r_box_max[2]),
            .o_min      (w_min[g]),
            .o_max      (w_max[g]),
            .o_center   (w_center[g]),
            .o_half     (w_half[g])
        );
    end

    assign o_in_ready  = w_rdy[0];
    assign o_out_valid = r_vld[4];

    assign o_aabb_min_x    = w_min[0];
    assign o_aabb_min_y    = w_min[1];
    assign o_aabb_min_z    = w_min[2];
    assign o_aabb_max_x    = w_max[0];
    assign o_aabb_max_y    = w_max[1];
    assign o_aabb_max_z    = w_max[2];
    assign o_center_x      = w_center[0];
    assign o_center_y      = w_center[1];
    assign o_center_z      = w_center[2];
    assign o_half_extent_x = w_half[0];
    assign o_half_extent_y = w_half[1];
    assign o_half_extent_z = w_half[2];

    `BTA_ASSERT_SAME(top_ready_when_empty, !r_vld[0], o_in_ready, "input stage empty but not ready")
    `BTA_ASSERT_NEXT(top_accept_fills, i_in_valid && o_in_ready, r_vld[0], "accepted item not captured")
    `BTA_ASSERT_NEXT(top_stall_holds, r_vld[4] && !i_out_ready,
                     r_vld[4] && $stable(o_aabb_min_x), "stalled result dropped")

endmodule

// ===== tb/sv/world_box_checker.sv =====
`timescale 1ns / 1ps
module world_box_checker (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [bta_pkg::CFG_IDX_W-1:0]          i_cfg_idx,
    input  logic [bta_pkg::WORD_BITS_DEF-1:0]      i_cfg_data,
    input  logic                                   i_in_valid,
    input  logic                                   i_in_ready,
    input  logic [11:0][bta_pkg::WORD_BITS_DEF-1:0] i_mat,
    input  logic                                   i_out_valid,
    input  logic                                   i_out_ready,
    input  logic [2:0][bta_pkg::WORD_BITS_DEF-1:0] i_lo,
    input  logic [2:0][bta_pkg::WORD_BITS_DEF-1:0] i_hi,
    input  logic [2:0][bta_pkg::WORD_BITS_DEF-1:0] i_mid,
    input  logic [2:0][bta_pkg::WORD_BITS_DEF-2:0] i_half,
    output int                                     o_fail_count,
    output int                                     o_pending
);
    localparam int W = bta_pkg::WORD_BITS_DEF;
    localparam int HW = W - 1;
    localparam int FRAC = bta_pkg::FRAC_BITS_DEF;
    localparam longint SAT_HI = (longint'(1) <<< (W - 1)) - 1;
    localparam longint SAT_LO = -SAT_HI - 1;
    localparam int REPORT_LIMIT = 60;

    typedef struct packed {
        logic [2:0][W-1:0]  lo;
        logic [2:0][W-1:0]  hi;
        logic [2:0][W-1:0]  mid;
        logic [2:0][HW-1:0] half;
    } world_box_t;

    logic [2:0][W-1:0] box_lo;
    logic [2:0][W-1:0] box_hi;
    world_box_t        placed_boxes[$];
    int                fails = 0;

    assign o_fail_count = fails;

    // One world coordinate of one corner: floored products, exact sum, one saturation.
    function automatic longint place_coord(logic [3:0][W-1:0] row, logic [W-1:0] x,
                                           logic [W-1:0] y, logic [W-1:0] z);
        longint acc;
        acc = (longint'($signed(row[0])) * longint'($signed(x))) >>> FRAC;
        acc += (longint'($signed(row[1])) * longint'($signed(y))) >>> FRAC;
        acc += (longint'($signed(row[2])) * longint'($signed(z))) >>> FRAC;
        acc += longint'($signed(row[3]));
        if (acc > SAT_HI) begin
            return SAT_HI;
        end
        if (acc < SAT_LO) begin
            return SAT_LO;
        end
        return acc;
    endfunction

    function automatic world_box_t predict_world_box(logic [11:0][W-1:0] m);
        world_box_t wb;
        longint     p;
        longint     lo;
        longint     hi;
        int         ax;
        int         k;
        lo = 0;
        hi = 0;
        for (ax = 0; ax < 3; ax++) begin
            for (k = 0; k < 8; k++) begin
                p = place_coord(m[ax*4 +: 4],
                                k[2] ? box_hi[0] : box_lo[0],
                                k[1] ? box_hi[1] : box_lo[1],
                                k[0] ? box_hi[2] : box_lo[2]);
                if (k == 0 || p < lo) begin
                    lo = p;
                end
                if (k == 0 || p > hi) begin
                    hi = p;
                end
            end
            wb.lo[ax]   = W'(lo);
            wb.hi[ax]   = W'(hi);
            wb.mid[ax]  = W'((lo + hi) >>> 1);
            wb.half[ax] = HW'((hi - lo) >>> 1);
        end
        return wb;
    endfunction

    task automatic check_field(string name, int ax, logic [W-1:0] want, logic [W-1:0] seen);
        if (want !== seen) begin
            fails++;
            if (fails <= REPORT_LIMIT) begin
                $display("%0t: %s[%0d] expected %0d got %0d", $time, name, ax,
                         $signed(want), $signed(seen));
            end
        end
    endtask

    always @(posedge i_clk) begin : watch
        world_box_t seen;
        world_box_t want;
        int         ax;
        if (!i_rst_n) begin
            box_lo = '0;
            box_hi = '0;
            placed_boxes.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                seen.lo   = i_lo;
                seen.hi   = i_hi;
                seen.mid  = i_mid;
                seen.half = i_half;
                if (placed_boxes.size() == 0) begin
                    fails++;
                    if (fails <= REPORT_LIMIT) begin
                        $display("%0t: result with no item outstanding, expected none, got min %0d %0d %0d max %0d %0d %0d",
                                 $time, $signed(seen.lo[0]), $signed(seen.lo[1]),
                                 $signed(seen.lo[2]), $signed(seen.hi[0]),
                                 $signed(seen.hi[1]), $signed(seen.hi[2]));
                    end
                end else begin
                    want = placed_boxes.pop_front();
                    for (ax = 0; ax < 3; ax++) begin
                        check_field("aabb_min", ax, want.lo[ax], seen.lo[ax]);
                        check_field("aabb_max", ax, want.hi[ax], seen.hi[ax]);
                        check_field("center", ax, want.mid[ax], seen.mid[ax]);
                        check_field("half_extent", ax, W'(want.half[ax]), W'(seen.half[ax]));
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                placed_boxes.push_back(predict_world_box(i_mat));
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    bta_pkg::CFG_BOX_MIN_X: box_lo[0] = i_cfg_data;
                    bta_pkg::CFG_BOX_MIN_Y: box_lo[1] = i_cfg_data;
                    bta_pkg::CFG_BOX_MIN_Z: box_lo[2] = i_cfg_data;
                    bta_pkg::CFG_BOX_MAX_X: box_hi[0] = i_cfg_data;
                    bta_pkg::CFG_BOX_MAX_Y: box_hi[1] = i_cfg_data;
                    bta_pkg::CFG_BOX_MAX_Z: box_hi[2] = i_cfg_data;
                    default: ;
                endcase
            end
        end
        o_pending <= placed_boxes.size();
    end

endmodule

// ===== tb/sv/tb_box_to_world_aabb.sv =====
`timescale 1ns / 1ps
module tb_box_to_world_aabb;

    localparam int W = bta_pkg::WORD_BITS_DEF;
    localparam int FRAC = bta_pkg::FRAC_BITS_DEF;
    localparam int IDX_W = bta_pkg::CFG_IDX_W;
    localparam logic [IDX_W-1:0] CFG_SPARE_A = 3'd6;
    localparam logic [IDX_W-1:0] CFG_SPARE_B = 3'd7;
    localparam logic [W-1:0] Q_ONE = W'(1) << FRAC;
    localparam logic [W-1:0] Q_HALF = Q_ONE >> 1;
    localparam logic [W-1:0] Q_LSB = W'(1);
    localparam logic [W-1:0] Q_NEG_LSB = '1;
    localparam logic [W-1:0] Q_MAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] Q_MIN = {1'b1, {(W-1){1'b0}}};
    localparam int COEF_SPAN = 4 << FRAC;
    localparam int BOX_SPAN = 8 << FRAC;
    localparam int MOVE_SPAN = 64 << FRAC;
    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_ITEMS = 115;

    typedef logic [11:0][W-1:0] t_matrix;
    typedef logic [2:0][W-1:0]  t_corner;
    typedef enum int {IDLE_MIXED, IDLE_NONE, IDLE_HEAVY} t_idle_mode;
    typedef enum int {BOX_SMALL, BOX_FULL, BOX_INVERTED, BOX_EXTREME} t_box_kind;

    localparam logic [2:0][IDX_W-1:0] MIN_IDX = {bta_pkg::CFG_BOX_MIN_Z,
                                                 bta_pkg::CFG_BOX_MIN_Y,
                                                 bta_pkg::CFG_BOX_MIN_X};
    localparam logic [2:0][IDX_W-1:0] MAX_IDX = {bta_pkg::CFG_BOX_MAX_Z,
                                                 bta_pkg::CFG_BOX_MAX_Y,
                                                 bta_pkg::CFG_BOX_MAX_X};

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic [IDX_W-1:0]  cfg_idx;
    logic [W-1:0]      cfg_data;
    logic              in_valid;
    logic              in_ready;
    t_matrix           mat;
    logic              out_valid;
    logic              out_ready;
    logic [2:0][W-1:0] aabb_lo;
    logic [2:0][W-1:0] aabb_hi;
    logic [2:0][W-1:0] aabb_mid;
    logic [2:0][W-2:0] aabb_half;
    int                fail_count;
    int                pending;
    t_idle_mode        idle_mode = IDLE_MIXED;
    int                n_items = 0;
    int                n_boxes = 0;

    box_to_world_aabb dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (in_valid),
        .o_in_ready      (in_ready),
        .i_m_r0c0        (mat[0]),
        .i_m_r0c1        (mat[1]),
        .i_m_r0c2        (mat[2]),
        .i_m_r0c3        (mat[3]),
        .i_m_r1c0        (mat[4]),
        .i_m_r1c1        (mat[5]),
        .i_m_r1c2        (mat[6]),
        .i_m_r1c3        (mat[7]),
        .i_m_r2c0        (mat[8]),
        .i_m_r2c1        (mat[9]),
        .i_m_r2c2        (mat[10]),
        .i_m_r2c3        (mat[11]),
        .o_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .o_aabb_min_x    (aabb_lo[0]),
        .o_aabb_min_y    (aabb_lo[1]),
        .o_aabb_min_z    (aabb_lo[2]),
        .o_aabb_max_x    (aabb_hi[0]),
        .o_aabb_max_y    (aabb_hi[1]),
        .o_aabb_max_z    (aabb_hi[2]),
        .o_center_x      (aabb_mid[0]),
        .o_center_y      (aabb_mid[1]),
        .o_center_z      (aabb_mid[2]),
        .o_half_extent_x (aabb_half[0]),
        .o_half_extent_y (aabb_half[1]),
        .o_half_extent_z (aabb_half[2])
    );

    world_box_checker checker_i (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_mat        (mat),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_lo         (aabb_lo),
        .i_hi         (aabb_hi),
        .i_mid        (aabb_mid),
        .i_half       (aabb_half),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        #10_000_000;
        $display("box_to_world_aabb regression: fail");
        $finish;
    end

    function automatic logic [W-1:0] q_int(int n);
        return W'(n) << FRAC;
    endfunction

    function automatic int pick_gap(t_idle_mode mode);
        int r;
        r = $urandom_range(0, 99);
        if (mode == IDLE_NONE) begin
            return 0;
        end
        if (mode == IDLE_HEAVY) begin
            r = r / 2 + 50;
        end
        if (r < 55) begin
            return 0;
        end
        if (r < 85) begin
            return $urandom_range(1, 3);
        end
        if (r < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [W-1:0] pick_special();
        case ($urandom_range(0, 5))
            0: return Q_MIN;
            1: return Q_MAX;
            2: return '0;
            3: return Q_NEG_LSB;
            4: return Q_ONE;
            default: return q_int(-1);
        endcase
    endfunction

    function automatic logic [W-1:0] rand_word(int span);
        case ($urandom_range(0, 15))
            0: return pick_special();
            1, 2: return W'($urandom);
            default: return W'($urandom_range(0, 2 * span) - span);
        endcase
    endfunction

    function automatic t_matrix rand_matrix();
        t_matrix m;
        int      i;
        for (i = 0; i < 12; i++) begin
            m[i] = rand_word((i % 4 == 3) ? MOVE_SPAN : COEF_SPAN);
        end
        return m;
    endfunction

    function automatic t_matrix scale_move(logic [W-1:0] sx, logic [W-1:0] sy, logic [W-1:0] sz,
                                           logic [W-1:0] tx, logic [W-1:0] ty,
                                           logic [W-1:0] tz);
        t_matrix m;
        m = '0;
        m[0]  = sx;
        m[3]  = tx;
        m[5]  = sy;
        m[7]  = ty;
        m[10] = sz;
        m[11] = tz;
        return m;
    endfunction

    task automatic push_matrix(t_matrix m);
        int gap;
        gap = pick_gap(idle_mode);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        mat <= m;
        do @(posedge clk); while (!in_ready);
        n_items++;
    endtask

    // Holds the sender off until every outstanding item has produced its result.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic program_box(t_corner bmin, t_corner bmax, bit poke_spare);
        int i;
        cfg_we <= 1'b1;
        for (i = 0; i < 3; i++) begin
            cfg_idx <= MIN_IDX[i];
            cfg_data <= bmin[i];
            @(posedge clk);
        end
        for (i = 0; i < 3; i++) begin
            cfg_idx <= MAX_IDX[i];
            cfg_data <= bmax[i];
            @(posedge clk);
        end
        if (poke_spare) begin
            cfg_idx <= CFG_SPARE_A;
            cfg_data <= W'($urandom);
            @(posedge clk);
            cfg_idx <= CFG_SPARE_B;
            cfg_data <= W'($urandom);
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        n_boxes++;
    endtask

    task automatic program_random_box(t_box_kind kind);
        t_corner a;
        t_corner b;
        t_corner lo;
        t_corner hi;
        int      i;
        for (i = 0; i < 3; i++) begin
            case (kind)
                BOX_FULL: begin
                    a[i] = W'($urandom);
                    b[i] = W'($urandom);
                end
                BOX_EXTREME: begin
                    a[i] = pick_special();
                    b[i] = pick_special();
                end
                default: begin
                    a[i] = W'($urandom_range(0, 2 * BOX_SPAN) - BOX_SPAN);
                    b[i] = W'($urandom_range(0, 2 * BOX_SPAN) - BOX_SPAN);
                end
            endcase
            if (($signed(a[i]) > $signed(b[i])) != (kind == BOX_INVERTED)) begin
                lo[i] = b[i];
                hi[i] = a[i];
            end else begin
                lo[i] = a[i];
                hi[i] = b[i];
            end
        end
        program_box(lo, hi, 1'($urandom_range(0, 1)));
    endtask

    initial begin : sink
        int stall;
        out_ready <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            out_ready <= 1'b1;
            repeat ($urandom_range(1, 16)) @(posedge clk);
            stall = pick_gap(idle_mode);
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
        end
    end

    initial begin : stimulus
        t_matrix m;
        int      phase;
        int      n;
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_idx <= '0;
        cfg_data <= '0;
        in_valid <= 1'b0;
        mat <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The box is a single point at the origin after reset.
        push_matrix('0);
        push_matrix({12{Q_MAX}});
        push_matrix({12{Q_MIN}});
        push_matrix({12{Q_NEG_LSB}});
        push_matrix(scale_move(Q_ONE, Q_ONE, Q_ONE, q_int(3), q_int(-2), Q_HALF));
        drain();

        program_box({q_int(-3), q_int(-2), q_int(-1)},
                    {q_int(3) + Q_HALF, q_int(2) + Q_HALF, Q_ONE + Q_HALF}, 1'b1);
        push_matrix(scale_move(Q_ONE, Q_ONE, Q_ONE, '0, '0, '0));
        push_matrix(scale_move(q_int(2), Q_HALF | q_int(-1), q_int(3),
                               q_int(10), q_int(20), q_int(-30)));
        m = scale_move('0, '0, Q_ONE, q_int(5), q_int(-7), Q_HALF);
        m[1] = q_int(-1);
        m[4] = Q_ONE;
        push_matrix(m);
        push_matrix({12{q_int(-1)}});
        push_matrix({12{Q_MAX}});
        push_matrix({12{Q_MIN}});
        push_matrix(scale_move(Q_ONE, Q_ONE, Q_ONE, Q_MAX, Q_MAX, Q_MAX));
        push_matrix(scale_move(Q_ONE, Q_ONE, Q_ONE, Q_MIN, Q_MIN, Q_MIN));
        // Sub-LSB products exercise rounding toward negative infinity.
        push_matrix(scale_move(Q_NEG_LSB, Q_LSB, Q_HALF, '0, '0, Q_NEG_LSB));
        drain();

        // Minimum above maximum on every axis.
        program_box({q_int(2), q_int(2), q_int(2)}, {q_int(-1), q_int(-1), q_int(-1)}, 1'b0);
        push_matrix(scale_move(Q_ONE, Q_ONE, Q_ONE, '0, '0, '0));
        push_matrix(m);
        drain();

        program_box({Q_MIN, Q_MIN, Q_MIN}, {Q_MAX, Q_MAX, Q_MAX}, 1'b1);
        push_matrix(scale_move(Q_ONE, Q_ONE, Q_ONE, '0, '0, '0));
        push_matrix({12{Q_MAX}});
        push_matrix({12{Q_MIN}});
        push_matrix(scale_move(Q_LSB, Q_LSB, Q_LSB, '0, '0, '0));
        push_matrix('0);

        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            drain();
            if (phase == 3) begin
                idle_mode = IDLE_NONE;
            end else if (phase == 6) begin
                idle_mode = IDLE_HEAVY;
            end else begin
                idle_mode = IDLE_MIXED;
            end
            program_random_box(t_box_kind'(phase % 4));
            for (n = 0; n < PHASE_ITEMS; n++) begin
                push_matrix(rand_matrix());
            end
        end

        drain();
        repeat (20) @(posedge clk);
        $display("Covered %0d matrices under %0d local box settings: zero, inverted,", n_items,
                 n_boxes);
        $display("full-range and saturating boxes, with mixed, absent and heavy idling.");
        if (fail_count == 0) begin
            $display("box_to_world_aabb regression: pass");
        end else begin
            $display("box_to_world_aabb regression: fail");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/bta_pkg.sv
hdl/bta_axis.sv
hdl/box_to_world_aabb.sv
tb/sv/world_box_checker.sv
tb/sv/tb_box_to_world_aabb.sv
